@@ design/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the piecewise-linear envelope core.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int MAX_POINTS = 16;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int SEG_W      = PTR_W + 1;
  localparam int LVL_W      = 16;
  localparam int DUR_W      = 24;
  localparam int NP_W       = 5;
  localparam int SCALE_W    = 16;
  localparam int TS_FRAC_W  = 8;
  localparam int LS_FRAC_W  = 12;
  localparam int CNT_W      = 40;
  localparam int SUM_W      = DUR_W + PTR_W;
  localparam int POS_W      = SUM_W + SCALE_W - TS_FRAC_W;
  localparam int FRAC_W     = 32;
  localparam int DIFF_W     = LVL_W + 1;
  localparam int DIV_W      = DIFF_W + FRAC_W;
  localparam int SLOPE_W    = 47;
  localparam int ACC_W      = CNT_W + SLOPE_W;
  localparam int RAM_W      = LVL_W + DUR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = '1;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_RESTART = 2'd2
  } ple_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED     = 3'd0,
    CFG_TIME_SCALE  = 3'd1,
    CFG_LEVEL_SCALE = 3'd2,
    CFG_NUM_POINTS  = 3'd3,
    CFG_MIN_DUR     = 3'd4,
    CFG_MAX_DUR     = 3'd5
  } ple_cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_ACC,
    S_POS,
    S_CHECK,
    S_LVL_RD,
    S_LVL_MUL,
    S_LVL_SAT,
    S_DIV,
    S_COUNT,
    S_MUL,
    S_FORM,
    S_EMIT
  } ple_state_t;

  typedef enum logic [1:0] {
    LVL_CUR,
    LVL_NEXT,
    LVL_HOLD
  } ple_lvl_sel_t;

  typedef struct packed {
    ple_action_t              action;
    logic [3:0]               point_index;
    logic signed [LVL_W-1:0]  point_level;
    logic [DUR_W-1:0]         point_duration;
  } ple_in_t;

  typedef struct packed {
    logic signed [LVL_W-1:0]  sample;
    logic                     finished;
  } ple_out_t;

endpackage

@@ design/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/piecewise_linear_envelope_core.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_envelope_core
// Breakpoint envelope generator: interpolates Q1.15 samples between stored
// breakpoints with a Q15.32 slope magnitude computed at each breakpoint.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel. Action LOAD stores a breakpoint (level and
//           clamped duration), RESTART rewinds the envelope,
//           TICK produces exactly one result on out_*.
//   out_* : valid/ready channel, one registered result per tick. A finished
//           result waits in the output register while the next item is taken.
//   cfg_* : register writes; the user must write only while the core is idle (not enforced).
// Tick sequence:
//   disabled: the result is emitted directly; final hold: one level read.
//   between breakpoints: a walk over the breakpoint RAM up to the current
//   segment (alternating read and accumulate) rebuilds the breakpoint position.
//   at a breakpoint: additionally the 49-step serial slope divider plus up
//   to two level reads.
// Reset: synchronous, active low; clears the sequencer and the envelope
// position, loads register defaults. Breakpoint RAM is not cleared.
// Output stall: results are held in the output register; a new tick stops
// before delivery until the register is free.
// ----------------------------------------------------------------------------
module piecewise_linear_envelope_core
  import ple_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ple_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ple_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SAT_W     = LVL_W + 5;
  localparam int PROD_W    = LVL_W + SCALE_W + 1;
  localparam int DCNT_W    = $clog2(DIV_W);
  localparam int DLO       = CNT_W / 2;
  localparam int MLO       = 24;
  localparam int PP_W      = DLO + MLO;
  localparam int TERM_BITS = 17;
  localparam int SUMS_W    = TERM_BITS + 2;
  localparam int HI_W      = ACC_W - FRAC_W;

  // configuration
  logic                enabled_r;
  logic [SCALE_W-1:0]  time_scale_r;
  logic [SCALE_W-1:0]  level_scale_r;
  logic [NP_W-1:0]     num_points_r;
  logic [DUR_W-1:0]    min_dur_r;
  logic [DUR_W-1:0]    max_dur_r;

  ple_state_t              state_r, state_nxt;
  logic [PTR_W-1:0]        rd_addr_r, rd_addr_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        cross_pos_r, cross_pos_nxt;
  logic                    crossed_r, crossed_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [SEG_W-1:0]        seg_r, seg_nxt;
  logic [POS_W-1:0]        seg_start_r, seg_start_nxt;
  logic signed [LVL_W-1:0] start_lvl_r, start_lvl_nxt;
  logic                    slope_neg_r, slope_neg_nxt;
  logic [SLOPE_W-1:0]      slope_mag_r, slope_mag_nxt;
  ple_lvl_sel_t            lvl_sel_r, lvl_sel_nxt;
  logic signed [PROD_W-1:0] lvl_prod_r, lvl_prod_nxt;
  logic [POS_W-1:0]        len_r, len_nxt;
  logic [DIV_W-1:0]        div_q_r, div_q_nxt;
  logic [POS_W-1:0]        rem_r, rem_nxt;
  logic [DCNT_W-1:0]       div_cnt_r, div_cnt_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [1:0]              mul_cnt_r, mul_cnt_nxt;
  ple_out_t                res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ple_out_t                out_data_r, out_data_nxt;

  logic                    in_fire;
  logic [PTR_W-1:0]        last;
  logic [SCALE_W-1:0]      ts_eff;
  logic [DUR_W-1:0]        dur_clamp;
  logic                    ram_we;
  logic [RAM_W-1:0]        ram_rdata;
  logic signed [LVL_W-1:0] rd_lvl;
  logic [DUR_W-1:0]        rd_dur;
  logic [SUM_W+SCALE_W-1:0] pos_prod;
  logic signed [PROD_W-1:0] lvl_mul;
  logic signed [LVL_W-1:0] lvl_sat;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]       diff_mag;
  logic [POS_W:0]          trial;
  logic [POS_W:0]          trial_sub;
  logic                    trial_ge;
  logic [DIV_W-1:0]        q_step;
  logic [CNT_W-1:0]        delta;
  logic [DLO-1:0]          d_part;
  logic [MLO-1:0]          m_part;
  logic [PP_W-1:0]         pp;
  logic [5:0]              pp_sh;
  logic [HI_W-1:0]         acc_hi;
  logic                    term_big;
  logic                    term_round;
  logic [TERM_BITS:0]      term_mag;
  logic signed [SUMS_W-1:0] s_ext;
  logic signed [SUMS_W-1:0] t_ext;
  logic signed [SUMS_W-1:0] form_sum;

  function automatic logic signed [LVL_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [LVL_W-1:0] r;
    if (v > SAT_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -SAT_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[LVL_W-1:0];
    end
    return r;
  endfunction

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (num_points_r == '0) begin
      last = '0;
    end else if (int'(num_points_r) > MAX_POINTS) begin
      last = PTR_W'(MAX_POINTS - 1);
    end else begin
      last = PTR_W'(num_points_r - 1'b1);
    end
  end

  assign ts_eff = (time_scale_r == '0) ? SCALE_W'(1) : time_scale_r;

  always_comb begin
    if (in_data.point_duration < min_dur_r) begin
      dur_clamp = min_dur_r;
    end else if (in_data.point_duration > max_dur_r) begin
      dur_clamp = max_dur_r;
    end else begin
      dur_clamp = in_data.point_duration;
    end
  end

  // breakpoint store; written only on a load transfer in idle, read only
  // by the tick sequencer, so accesses never overlap
  assign ram_we = in_fire && (in_data.action == ACT_LOAD) &&
                  (int'(in_data.point_index) < MAX_POINTS);

  ple_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_bp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PTR_W'(in_data.point_index)),
    .wdata ({in_data.point_level, dur_clamp}),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign rd_lvl = $signed(ram_rdata[RAM_W-1:DUR_W]);
  assign rd_dur = ram_rdata[DUR_W-1:0];

  // datapath
  assign pos_prod = (SUM_W+SCALE_W)'(sum_r) * (SUM_W+SCALE_W)'(ts_eff);
  assign lvl_mul  = rd_lvl * $signed({1'b0, level_scale_r});
  assign lvl_sat  = sat16($signed(lvl_prod_r[PROD_W-1:LS_FRAC_W]));
  assign diff     = DIFF_W'(lvl_sat) - DIFF_W'(start_lvl_r);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign trial     = {rem_r, div_q_r[DIV_W-1]};
  assign trial_ge  = trial >= {1'b0, len_r};
  assign trial_sub = trial - {1'b0, len_r};
  assign q_step    = {div_q_r[DIV_W-2:0], trial_ge};

  assign delta  = count_r - CNT_W'(seg_start_r);
  assign d_part = mul_cnt_r[0] ? delta[CNT_W-1:DLO] : delta[DLO-1:0];
  assign m_part = mul_cnt_r[1] ? MLO'(slope_mag_r[SLOPE_W-1:MLO]) : slope_mag_r[MLO-1:0];
  assign pp     = PP_W'(d_part) * PP_W'(m_part);
  assign pp_sh  = (mul_cnt_r[0] ? 6'(DLO) : 6'd0) + (mul_cnt_r[1] ? 6'(MLO) : 6'd0);

  assign acc_hi     = acc_r[ACC_W-1:FRAC_W];
  assign term_big   = |acc_hi[HI_W-1:TERM_BITS];
  assign term_round = slope_neg_r && (|acc_r[FRAC_W-1:0]);
  assign term_mag   = term_big ? {1'b1, {TERM_BITS{1'b0}}}
                               : {1'b0, acc_hi[TERM_BITS-1:0]} + (TERM_BITS+1)'(term_round);
  assign s_ext      = SUMS_W'(start_lvl_r);
  assign t_ext      = $signed({1'b0, term_mag});
  assign form_sum   = slope_neg_r ? (s_ext - t_ext) : (s_ext + t_ext);

  always_comb begin
    state_nxt     = state_r;
    rd_addr_nxt   = rd_addr_r;
    sum_nxt       = sum_r;
    pos_nxt       = pos_r;
    cross_pos_nxt = cross_pos_r;
    crossed_nxt   = crossed_r;
    count_nxt     = count_r;
    seg_nxt       = seg_r;
    seg_start_nxt = seg_start_r;
    start_lvl_nxt = start_lvl_r;
    slope_neg_nxt = slope_neg_r;
    slope_mag_nxt = slope_mag_r;
    lvl_sel_nxt   = lvl_sel_r;
    lvl_prod_nxt  = lvl_prod_r;
    len_nxt       = len_r;
    div_q_nxt     = div_q_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    acc_nxt       = acc_r;
    mul_cnt_nxt   = mul_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.action)
            ACT_TICK: begin
              if (!enabled_r) begin
                res_nxt   = '0;
                state_nxt = S_EMIT;
              end else if (seg_r > SEG_W'(last)) begin
                state_nxt = S_COUNT;
              end else begin
                sum_nxt     = '0;
                crossed_nxt = 1'b0;
                rd_addr_nxt = PTR_W'(1);
                state_nxt   = (seg_r == '0) ? S_POS : S_WALK_RD;
              end
            end
            ACT_RESTART: begin
              count_nxt     = '0;
              seg_nxt       = '0;
              seg_start_nxt = '0;
              start_lvl_nxt = '0;
              slope_neg_nxt = 1'b0;
              slope_mag_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_ACC;
      end
      S_WALK_ACC: begin
        sum_nxt = sum_r + SUM_W'(rd_dur);
        if ({1'b0, rd_addr_r} == seg_r) begin
          state_nxt = S_POS;
        end else begin
          rd_addr_nxt = rd_addr_r + 1'b1;
          state_nxt   = S_WALK_RD;
        end
      end
      S_POS: begin
        pos_nxt   = pos_prod[SUM_W+SCALE_W-1:TS_FRAC_W];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (CNT_W'(pos_r) <= count_r) begin
          crossed_nxt   = 1'b1;
          cross_pos_nxt = pos_r;
          seg_nxt       = seg_r + 1'b1;
          if (seg_r >= SEG_W'(last)) begin
            rd_addr_nxt = seg_r[PTR_W-1:0];
            lvl_sel_nxt = LVL_CUR;
            state_nxt   = S_LVL_RD;
          end else begin
            rd_addr_nxt = seg_r[PTR_W-1:0] + 1'b1;
            state_nxt   = S_WALK_RD;
          end
        end else if (crossed_r) begin
          rd_addr_nxt = PTR_W'(seg_r - 1'b1);
          lvl_sel_nxt = LVL_CUR;
          state_nxt   = S_LVL_RD;
        end else begin
          state_nxt = S_COUNT;
        end
      end
      S_LVL_RD: begin
        state_nxt = S_LVL_MUL;
      end
      S_LVL_MUL: begin
        lvl_prod_nxt = lvl_mul;
        state_nxt    = S_LVL_SAT;
      end
      S_LVL_SAT: begin
        unique case (lvl_sel_r)
          LVL_CUR: begin
            start_lvl_nxt = lvl_sat;
            seg_start_nxt = cross_pos_r;
            slope_neg_nxt = 1'b0;
            slope_mag_nxt = '0;
            if (seg_r <= SEG_W'(last)) begin
              rd_addr_nxt = seg_r[PTR_W-1:0];
              lvl_sel_nxt = LVL_NEXT;
              state_nxt   = S_LVL_RD;
            end else begin
              state_nxt = S_COUNT;
            end
          end
          LVL_NEXT: begin
            if ((diff != '0) && (pos_r > cross_pos_r)) begin
              div_q_nxt     = {diff_mag, {FRAC_W{1'b0}}};
              rem_nxt       = '0;
              len_nxt       = pos_r - cross_pos_r;
              div_cnt_nxt   = DCNT_W'(DIV_W - 1);
              slope_neg_nxt = diff[DIFF_W-1];
              state_nxt     = S_DIV;
            end else begin
              state_nxt = S_COUNT;
            end
          end
          LVL_HOLD: begin
            res_nxt.sample   = lvl_sat;
            res_nxt.finished = 1'b1;
            state_nxt        = S_EMIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        rem_nxt     = trial_ge ? trial_sub[POS_W-1:0] : trial[POS_W-1:0];
        div_q_nxt   = q_step;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          slope_mag_nxt = (|q_step[DIV_W-1:SLOPE_W]) ? SLOPE_MAX : q_step[SLOPE_W-1:0];
          state_nxt     = S_COUNT;
        end
      end
      S_COUNT: begin
        count_nxt = count_r + 1'b1;
        if (seg_r > SEG_W'(last)) begin
          rd_addr_nxt = last;
          lvl_sel_nxt = LVL_HOLD;
          state_nxt   = S_LVL_RD;
        end else begin
          acc_nxt     = '0;
          mul_cnt_nxt = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        acc_nxt     = acc_r + (ACC_W'(pp) << pp_sh);
        mul_cnt_nxt = mul_cnt_r + 1'b1;
        if (mul_cnt_r == 2'd3) begin
          state_nxt = S_FORM;
        end
      end
      S_FORM: begin
        res_nxt.sample   = sat16(SAT_W'(form_sum));
        res_nxt.finished = 1'b0;
        state_nxt        = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_nxt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      seg_r         <= '0;
      seg_start_r   <= '0;
      start_lvl_r   <= '0;
      slope_neg_r   <= 1'b0;
      slope_mag_r   <= '0;
      out_valid_r   <= 1'b0;
      enabled_r     <= 1'b0;
      time_scale_r  <= SCALE_W'(256);
      level_scale_r <= SCALE_W'(4096);
      num_points_r  <= NP_W'(1);
      min_dur_r     <= DUR_W'(1);
      max_dur_r     <= '1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      seg_r       <= seg_nxt;
      seg_start_r <= seg_start_nxt;
      start_lvl_r <= start_lvl_nxt;
      slope_neg_r <= slope_neg_nxt;
      slope_mag_r <= slope_mag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLED:     enabled_r     <= cfg_wdata[0];
          CFG_TIME_SCALE:  time_scale_r  <= cfg_wdata[SCALE_W-1:0];
          CFG_LEVEL_SCALE: level_scale_r <= cfg_wdata[SCALE_W-1:0];
          CFG_NUM_POINTS:  num_points_r  <= cfg_wdata[NP_W-1:0];
          CFG_MIN_DUR:     min_dur_r     <= cfg_wdata[DUR_W-1:0];
          CFG_MAX_DUR:     max_dur_r     <= cfg_wdata[DUR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    sum_r       <= sum_nxt;
    pos_r       <= pos_nxt;
    cross_pos_r <= cross_pos_nxt;
    crossed_r   <= crossed_nxt;
    lvl_sel_r   <= lvl_sel_nxt;
    lvl_prod_r  <= lvl_prod_nxt;
    len_r       <= len_nxt;
    div_q_r     <= div_q_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    acc_r       <= acc_nxt;
    mul_cnt_r   <= mul_cnt_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r <= SEG_W'(MAX_POINTS))
    else $error("segment number beyond breakpoint count");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.action == ACT_RESTART) |=>
      (count_r == '0) && (seg_r == '0) && (slope_mag_r == '0))
    else $error("restart did not rewind the envelope");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (len_r != '0))
    else $error("slope divide started with zero segment length");

  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.action == ACT_TICK) && !enabled_r |=>
      $stable(count_r) && $stable(seg_r))
    else $error("disabled tick moved the envelope");

  a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && out_valid_r && !out_ready |=> (state_r == S_EMIT))
    else $error("result dropped while output register full");
`endif

endmodule
